>>> sv/packbits_run_length_encoder_macros.svh
// Assertion macros for the PackBits encoder.
// Used by the top level only; no other dependencies.
`ifndef PACKBITS_RUN_LENGTH_ENCODER_MACROS_SVH
`define PACKBITS_RUN_LENGTH_ENCODER_MACROS_SVH

// same-cycle implication
`define PBE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/pbe_pkg.sv
// Package for the PackBits encoder: sequencer states, emit request type, constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pbe_pkg;

  localparam int BYTE_W = 8;
  localparam int RUN_W  = 8;
  localparam int HDR_W  = 9;

  localparam logic [HDR_W-1:0]  RUN_BASE = 9'd257;
  localparam logic [BYTE_W-1:0] END_MARK = 8'd128;
  localparam logic [RUN_W-1:0]  MIN_RUN  = 8'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_AFTER,
    ST_LCLOSE,
    ST_LFLUSH,
    ST_RUN_HDR,
    ST_RUN_BYTE,
    ST_FL_HDR,
    ST_FL_RD,
    ST_FL_DAT,
    ST_END
  } pbe_state_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              last;
  } pbe_emit_t;

endpackage
`default_nettype wire

>>> sv/pbe_in_if.sv
// Input channel: one stream byte per item with its last-byte flag.
// Depends on pbe_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface pbe_in_if;
  logic                      valid;
  logic                      ready;
  logic [pbe_pkg::BYTE_W-1:0] in_byte;
  logic                      last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface
`default_nettype wire

>>> sv/pbe_out_if.sv
// Output channel: one coded byte per item, flagged on the end marker.
// Depends on pbe_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface pbe_out_if;
  logic                      valid;
  logic                      ready;
  logic [pbe_pkg::BYTE_W-1:0] out_byte;
  logic                      last_out;

  modport source (output valid, output out_byte, output last_out, input ready);
  modport sink   (input valid, input out_byte, input last_out, output ready);
endinterface
`default_nettype wire

>>> sv/packbits_run_length_encoder.sv
// PackBits encoder top level. An item with no result steps through accept, decide, after;
// a run code adds header and byte steps, a literal flush a header step plus a registered
// store read and data step per byte; the end of stream close, flush and end marker steps.
// Output back-pressure stretches any emitting step. One item is in work at a time.
// rst is synchronous: clears the sequencer, run and literal counts; store contents stay.
`timescale 1ns / 1ps
`default_nettype none
`include "packbits_run_length_encoder_macros.svh"
module packbits_run_length_encoder #(
  parameter int MAX_LIT = 32,
  parameter int MAX_RUN = 128
) (
  input wire logic  clk,
  input wire logic  rst,
  pbe_in_if.sink    in_ch,
  pbe_out_if.source out_ch
);

  localparam int AW = (MAX_LIT > 1) ? $clog2(MAX_LIT) : 1;

  pbe_pkg::pbe_emit_t         emit;
  logic                       out_free;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [pbe_pkg::BYTE_W-1:0] wr_data;
  logic [AW-1:0]              rd_addr;
  logic [pbe_pkg::BYTE_W-1:0] rd_data;
  logic                       in_accept;

  assign in_accept = in_ch.valid && in_ch.ready;

  pbe_ctrl #(
    .MAX_LIT (MAX_LIT),
    .MAX_RUN (MAX_RUN),
    .AW      (AW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .free    (out_free),
    .emit    (emit),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pbe_lit_store #(
    .DEPTH (MAX_LIT),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pbe_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .emit   (emit),
    .free   (out_free),
    .out_ch (out_ch)
  );

  `PBE_ASSERT_IMP(a_emit_free, clk, rst, emit.valid, out_free, "item emitted while output busy")
  `PBE_ASSERT_NXT(a_busy_after_accept, clk, rst, in_accept, !in_ch.ready, "ready after accept")
  `PBE_ASSERT_IMP(a_no_write_on_emit, clk, rst, wr_en, !emit.valid, "store write while emitting")

endmodule
`default_nettype wire

>>> sv/pbe_lit_store.sv
// Literal byte store: one write port, one registered read port.
// Depends on pbe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pbe_lit_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [pbe_pkg::BYTE_W-1:0] wr_data,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [pbe_pkg::BYTE_W-1:0] rd_data
);

  logic [pbe_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> sv/pbe_out_reg.sv
// Output register between the sequencer and the output channel.
// Depends on pbe_pkg and pbe_out_if.
`timescale 1ns / 1ps
`default_nettype none
module pbe_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pbe_pkg::pbe_emit_t emit,
  output logic                   free,
  pbe_out_if.source              out_ch
);

  logic                       ov;
  logic [pbe_pkg::BYTE_W-1:0] ob;
  logic                       ol;

  assign free            = !ov || out_ch.ready;
  assign out_ch.valid    = ov;
  assign out_ch.out_byte = ob;
  assign out_ch.last_out = ol;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (free) begin
      ov <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && emit.valid) begin
      ob <= emit.data;
      ol <= emit.last;
    end
  end

endmodule
`default_nettype wire

>>> sv/pbe_ctrl.sv
// Sequencer for the PackBits encoder: run tracking, literal bookkeeping,
// shared header subtractor. Depends on pbe_pkg and pbe_in_if.
`timescale 1ns / 1ps
`default_nettype none
module pbe_ctrl #(
  parameter int MAX_LIT = 32,
  parameter int MAX_RUN = 128,
  parameter int AW      = 5
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  pbe_in_if.sink                          in_ch,
  input  wire logic                       free,
  output pbe_pkg::pbe_emit_t              emit,
  output logic                            wr_en,
  output logic      [AW-1:0]              wr_addr,
  output logic      [pbe_pkg::BYTE_W-1:0] wr_data,
  output logic      [AW-1:0]              rd_addr,
  input  wire logic [pbe_pkg::BYTE_W-1:0] rd_data
);

  localparam int CW = $clog2(MAX_LIT + 1);

  pbe_pkg::pbe_state_t state, state_next;

  logic                        phase_last;
  logic                        last_q;
  logic [pbe_pkg::BYTE_W-1:0]  byte_q;
  logic [pbe_pkg::BYTE_W-1:0]  held;
  logic                        have;
  logic [pbe_pkg::RUN_W-1:0]   run;
  logic [CW-1:0]               count;
  logic [CW-1:0]               idx;

  logic                        same, can_grow, is_run, lit_full, idx_done;
  logic [pbe_pkg::HDR_W-1:0]   hdr_a, hdr_b, hdr;

  assign same     = byte_q == held;
  assign can_grow = run < pbe_pkg::RUN_W'(MAX_RUN);
  assign is_run   = run >= pbe_pkg::MIN_RUN;
  assign lit_full = (count + CW'(1)) == CW'(MAX_LIT);
  assign idx_done = (idx + CW'(1)) == count;

  // shared header unit: 257 - run, or count - 1
  always_comb begin
    if (state == pbe_pkg::ST_FL_HDR) begin
      hdr_a = pbe_pkg::HDR_W'(count);
      hdr_b = pbe_pkg::HDR_W'(1);
    end else begin
      hdr_a = pbe_pkg::RUN_BASE;
      hdr_b = pbe_pkg::HDR_W'(run);
    end
    hdr = hdr_a - hdr_b;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pbe_pkg::ST_IDLE: begin
        if (in_ch.valid) state_next = pbe_pkg::ST_DECIDE;
      end
      pbe_pkg::ST_DECIDE: begin
        if (!have) begin
          state_next = pbe_pkg::ST_AFTER;
        end else if (same && can_grow) begin
          state_next = (run == pbe_pkg::RUN_W'(1) && count != '0) ?
                       pbe_pkg::ST_FL_HDR : pbe_pkg::ST_AFTER;
        end else if (is_run) begin
          state_next = pbe_pkg::ST_RUN_HDR;
        end else begin
          state_next = lit_full ? pbe_pkg::ST_FL_HDR : pbe_pkg::ST_AFTER;
        end
      end
      pbe_pkg::ST_AFTER: begin
        state_next = last_q ? pbe_pkg::ST_LCLOSE : pbe_pkg::ST_IDLE;
      end
      pbe_pkg::ST_LCLOSE: begin
        state_next = is_run ? pbe_pkg::ST_RUN_HDR : pbe_pkg::ST_LFLUSH;
      end
      pbe_pkg::ST_LFLUSH: begin
        state_next = (count != '0) ? pbe_pkg::ST_FL_HDR : pbe_pkg::ST_END;
      end
      pbe_pkg::ST_RUN_HDR: begin
        if (free) state_next = pbe_pkg::ST_RUN_BYTE;
      end
      pbe_pkg::ST_RUN_BYTE: begin
        if (free) state_next = phase_last ? pbe_pkg::ST_LFLUSH : pbe_pkg::ST_AFTER;
      end
      pbe_pkg::ST_FL_HDR: begin
        if (free) state_next = pbe_pkg::ST_FL_RD;
      end
      pbe_pkg::ST_FL_RD: begin
        state_next = pbe_pkg::ST_FL_DAT;
      end
      pbe_pkg::ST_FL_DAT: begin
        if (free) begin
          if (!idx_done)       state_next = pbe_pkg::ST_FL_RD;
          else if (phase_last) state_next = pbe_pkg::ST_END;
          else                 state_next = pbe_pkg::ST_AFTER;
        end
      end
      pbe_pkg::ST_END: begin
        if (free) state_next = pbe_pkg::ST_IDLE;
      end
      default: state_next = pbe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    emit        = '0;
    wr_en       = 1'b0;
    wr_addr     = count[AW-1:0];
    wr_data     = held;
    rd_addr     = idx[AW-1:0];
    unique case (state)
      pbe_pkg::ST_IDLE: in_ch.ready = 1'b1;
      pbe_pkg::ST_DECIDE: begin
        wr_en = have && !(same && can_grow) && !is_run;
      end
      pbe_pkg::ST_LCLOSE: wr_en = !is_run;
      pbe_pkg::ST_RUN_HDR: begin
        emit.valid = free;
        emit.data  = hdr[pbe_pkg::BYTE_W-1:0];
      end
      pbe_pkg::ST_RUN_BYTE: begin
        emit.valid = free;
        emit.data  = held;
      end
      pbe_pkg::ST_FL_HDR: begin
        emit.valid = free;
        emit.data  = hdr[pbe_pkg::BYTE_W-1:0];
      end
      pbe_pkg::ST_FL_DAT: begin
        emit.valid = free;
        emit.data  = rd_data;
      end
      pbe_pkg::ST_END: begin
        emit.valid = free;
        emit.data  = pbe_pkg::END_MARK;
        emit.last  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_last <= 1'b0;
      have       <= 1'b0;
      held       <= '0;
      run        <= '0;
      count      <= '0;
      idx        <= '0;
    end else begin
      case (state)
        pbe_pkg::ST_IDLE: begin
          if (in_ch.valid) begin
            byte_q <= in_ch.in_byte;
            last_q <= in_ch.last_byte;
          end
        end
        pbe_pkg::ST_DECIDE: begin
          if (!have) begin
            held <= byte_q;
            have <= 1'b1;
            run  <= pbe_pkg::RUN_W'(1);
          end else if (same && can_grow) begin
            run <= run + pbe_pkg::RUN_W'(1);
          end else if (!is_run) begin
            held  <= byte_q;
            run   <= pbe_pkg::RUN_W'(1);
            count <= count + CW'(1);
          end
        end
        pbe_pkg::ST_AFTER: begin
          if (last_q) phase_last <= 1'b1;
        end
        pbe_pkg::ST_LCLOSE: begin
          if (!is_run) count <= count + CW'(1);
        end
        pbe_pkg::ST_RUN_BYTE: begin
          if (free && !phase_last) begin
            held <= byte_q;
            run  <= pbe_pkg::RUN_W'(1);
          end
        end
        pbe_pkg::ST_FL_HDR: begin
          if (free) idx <= '0;
        end
        pbe_pkg::ST_FL_DAT: begin
          if (free) begin
            idx <= idx + CW'(1);
            if (idx_done) count <= '0;
          end
        end
        pbe_pkg::ST_END: begin
          if (free) begin
            held       <= '0;
            have       <= 1'b0;
            run        <= '0;
            phase_last <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> verif/packbits_encoder_checker.sv
`timescale 1ns / 1ps
// Checker for the PackBits encoder: watches both channels, predicts the coded bytes
// and compares every accepted output item with the oldest prediction.
// Depends on pbe_pkg, pbe_in_if and pbe_out_if.
module packbits_encoder_checker #(
  parameter int MAX_LIT = 32,
  parameter int MAX_RUN = 128
) (
  input wire logic clk,
  input wire logic rst,
  pbe_in_if        in_ch,
  pbe_out_if       out_ch,
  output int       fail_count,
  output int       pending
);
  localparam int BYTE_W = pbe_pkg::BYTE_W;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } coded_t;

  coded_t            coded_q[$];
  logic [BYTE_W-1:0] held_byte;
  bit                have_held;
  int                run_len;
  logic [BYTE_W-1:0] lit_store [MAX_LIT];
  int                lit_cnt;

  function automatic void put_coded(input logic [BYTE_W-1:0] b, input logic lst);
    coded_t c;
    c.data = b;
    c.last = lst;
    coded_q = {coded_q, c};
  endfunction

  function automatic void flush_literals();
    int i;
    if (lit_cnt == 0) return;
    put_coded(BYTE_W'(lit_cnt - 1), 1'b0);
    for (i = 0; i < lit_cnt; i++) put_coded(lit_store[i], 1'b0);
    lit_cnt = 0;
  endfunction

  function automatic void store_literal(input logic [BYTE_W-1:0] b);
    if (lit_cnt < MAX_LIT) begin
      lit_store[lit_cnt] = b;
      lit_cnt++;
    end
    if (lit_cnt >= MAX_LIT) flush_literals();
  endfunction

  function automatic void close_held();
    if (run_len >= int'(pbe_pkg::MIN_RUN)) begin
      put_coded(BYTE_W'(int'(pbe_pkg::RUN_BASE) - run_len), 1'b0);
      put_coded(held_byte, 1'b0);
    end else begin
      store_literal(held_byte);
    end
  endfunction

  function automatic void encode_byte(input logic [BYTE_W-1:0] b, input logic lst);
    if (!have_held) begin
      held_byte = b;
      have_held = 1'b1;
      run_len = 1;
    end else if (b == held_byte && run_len < MAX_RUN) begin
      // a run begins: pending literals go out first
      if (run_len == 1) flush_literals();
      run_len++;
    end else begin
      close_held();
      held_byte = b;
      run_len = 1;
    end
    if (lst) begin
      close_held();
      flush_literals();
      put_coded(pbe_pkg::END_MARK, 1'b1);
      held_byte = '0;
      have_held = 1'b0;
      run_len = 0;
    end
  endfunction

  always @(posedge clk) begin
    coded_t want;
    coded_t got;
    if (rst) begin
      coded_q.delete();
      held_byte = '0;
      have_held = 1'b0;
      run_len = 0;
      lit_cnt = 0;
      fail_count = 0;
    end else begin
      // outputs first: an output at this edge never stems from an input at this edge
      if (out_ch.valid && out_ch.ready) begin
        got.data = out_ch.out_byte;
        got.last = out_ch.last_out;
        if (coded_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected item: expected none, actual byte %h last %b",
                   $time, got.data, got.last);
        end else begin
          want = coded_q.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: mismatch: expected byte %h last %b, actual byte %h last %b",
                     $time, want.data, want.last, got.data, got.last);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) encode_byte(in_ch.in_byte, in_ch.last_byte);
    end
    pending = coded_q.size();
  end

endmodule

>>> verif/packbits_run_length_encoder_test.sv
`timescale 1ns / 1ps
// Top of the PackBits encoder testbench: clock, reset, byte stream stimulus, receiver
// stalls and the verdict. Depends on pbe_pkg, both channel interfaces, the encoder and
// packbits_encoder_checker.
module packbits_run_length_encoder_test;
  localparam int BYTE_W      = pbe_pkg::BYTE_W;
  localparam int LIT_CAP     = 32;
  localparam int RUN_CAP     = 128;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 360;

  logic clk      = 1'b0;
  logic rst      = 1'b1;
  logic rx_ready = 1'b0;

  int items_sent  = 0;
  int phase       = 1;
  int tx_idle_pct = 10;
  int rx_idle_pct = 70;
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  int fail_count;
  int pending;

  logic [BYTE_W-1:0] stream_q[$];

  pbe_in_if  in_ch();
  pbe_out_if out_ch();

  assign out_ch.ready = rx_ready;

  packbits_run_length_encoder #(
    .MAX_LIT(LIT_CAP),
    .MAX_RUN(RUN_CAP)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  packbits_encoder_checker #(
    .MAX_LIT(LIT_CAP),
    .MAX_RUN(RUN_CAP)
  ) coded_check (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off once well into the run
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rx_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_sent >= 260) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      rx_ready <= 1'b0;
    end else begin
      rx_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void add_run(input logic [BYTE_W-1:0] b, input int n);
    int i;
    for (i = 0; i < n; i++) stream_q = {stream_q, b};
  endfunction

  // adjacent bytes differ, so no two of them form a run
  function automatic void add_literals(input int n);
    int i;
    logic [BYTE_W-1:0] b;
    for (i = 0; i < n; i++) begin
      b = BYTE_W'($urandom_range(0, 255));
      if (stream_q.size() > 0 && b == stream_q[$]) b = b + 1'b1;
      stream_q = {stream_q, b};
    end
  endfunction

  // tiny alphabet: short runs and literals interleaved
  function automatic void add_noise(input int n);
    int i;
    logic [BYTE_W-1:0] b;
    for (i = 0; i < n; i++) begin
      b = BYTE_W'($urandom_range(0, 2));
      if (b == 8'd2) b = 8'hFF;
      stream_q = {stream_q, b};
    end
  endfunction

  function automatic void build_random_stream();
    int nseg;
    int s;
    int k;
    nseg = $urandom_range(1, 4);
    for (s = 0; s < nseg; s++) begin
      k = $urandom_range(0, 99);
      if (k < 35)      add_run(BYTE_W'($urandom_range(0, 255)), $urandom_range(2, 8));
      else if (k < 45) add_run(BYTE_W'($urandom_range(0, 255)), $urandom_range(9, 40));
      else if (k < 75) add_literals($urandom_range(1, 8));
      else if (k < 82) add_literals($urandom_range(28, 36));
      else if (k < 84) add_run(BYTE_W'($urandom_range(0, 255)), $urandom_range(126, 131));
      else             add_noise($urandom_range(1, 12));
    end
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic lst);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= b;
    in_ch.last_byte <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // sender pauses until every predicted item has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_stream();
    int i;
    int next_phase;
    for (i = 0; i < stream_q.size(); i++) send_byte(stream_q[i], i == stream_q.size() - 1);
    stream_q.delete();
    next_phase = (items_sent < 120) ? 1 : (items_sent < 240) ? 2 : 3;
    if (next_phase != phase) begin
      drain();
      phase = next_phase;
      tx_idle_pct = (phase == 2) ? 70 : 0;
      rx_idle_pct = (phase == 2) ? 10 : 0;
    end
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.in_byte   = '0;
    in_ch.last_byte = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // one-byte streams at both extremes
    add_run(8'h00, 1);
    send_stream();
    add_run(8'hFF, 1);
    send_stream();
    // shortest run, shortest literal pair
    add_run(8'hAA, 2);
    send_stream();
    add_run(8'h01, 1);
    add_run(8'h02, 1);
    send_stream();
    // run then literal closing the stream; literal then run
    add_run(8'h55, 3);
    add_run(8'h80, 1);
    send_stream();
    add_run(8'h10, 1);
    add_run(8'h20, 3);
    send_stream();
    add_run(8'h7F, 1);
    add_run(8'h80, 1);
    add_run(8'h7F, 1);
    send_stream();

    // full literal store, then a run past its cap
    add_literals($urandom_range(LIT_CAP, LIT_CAP + 6));
    add_run(BYTE_W'($urandom_range(0, 255)), $urandom_range(RUN_CAP + 1, RUN_CAP + 4));
    send_stream();

    while (items_sent < ITEM_TARGET) begin
      build_random_stream();
      send_stream();
    end

    drain();
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
